[design/rhp_pkg.sv]
// Shared types, widths and codes for the RTP header parser and sequence checker.
`timescale 1ns / 1ps

package rhp_pkg;

   localparam int MAX_PACKET_BYTES = 2048;

   // Byte counter saturates one above the largest legal packet
   localparam int POS_W  = $clog2(MAX_PACKET_BYTES + 2);
   localparam int TOT_W  = POS_W + 1;
   // Header end: 12 + 4*15 + 4 + 4*65535 fits in 19 bits
   localparam int HEND_W = 19;
   localparam int OFF_W  = 12;

   localparam int BYTE_W  = 8;
   localparam int PT_W    = 7;
   localparam int SEQ_W   = 16;
   localparam int TS_W    = 32;
   localparam int SRC_W   = 32;
   localparam int LIMIT_W = 31;
   localparam int WIN_W   = 15;

   localparam int FIXED_HDR_BYTES = 12;
   localparam logic [1:0] RTP_VERSION = 2'd2;

   localparam logic [LIMIT_W-1:0] JUMP_LIMIT_RESET = LIMIT_W'(100000);
   localparam logic [WIN_W-1:0]   WINDOW_RESET     = WIN_W'(64);

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_JUMP_LIMIT = 1'b0;
   localparam logic CSR_IDX_WINDOW     = 1'b1;

   typedef enum logic [2:0] {
      ST_IN_ORDER  = 3'd0,
      ST_MALFORMED = 3'd1,
      ST_OLD       = 3'd2,
      ST_PREMATURE = 3'd3,
      ST_PENDING   = 3'd4
   } rhp_status_type;

   typedef enum logic [1:0] {
      PH_FIXED   = 2'd0,
      PH_EXT_LEN = 2'd1,
      PH_DONE    = 2'd2
   } rhp_phase_type;

   // Packet summary, valid on the final byte
   typedef struct packed {
      logic               bad;
      logic [BYTE_W-1:0]  second_byte;
      logic [SEQ_W-1:0]   seq;
      logic [TS_W-1:0]    ts;
      logic [SRC_W-1:0]   src;
      logic [OFF_W-1:0]   offset;
      logic [OFF_W-1:0]   size;
   } rhp_packet_type;

   typedef struct packed {
      rhp_status_type     status;
      logic               ts_warn;
      logic               ssrc_warn;
      logic [PT_W-1:0]    payload_type;
      logic               marker;
      logic [SEQ_W-1:0]   seq;
      logic [TS_W-1:0]    ts;
      logic [SRC_W-1:0]   src;
      logic [OFF_W-1:0]   offset;
      logic [OFF_W-1:0]   size;
   } rhp_result_type;

endpackage

[design/rhp_parse.sv]
// Byte-wise RTP header capture, extension skip and padding strip.
`timescale 1ns / 1ps

module rhp_parse (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step,
   input  logic [rhp_pkg::BYTE_W-1:0]   rx_byte,
   input  logic                         last_byte,
   output rhp_pkg::rhp_packet_type      pkt
);
   import rhp_pkg::*;

   logic [POS_W-1:0]   pos_ff, pos_in;
   rhp_phase_type      phase_ff, phase_in;
   logic [BYTE_W-1:0]  flags_ff, flags_in;
   logic [BYTE_W-1:0]  second_ff, second_in;
   logic [SEQ_W-1:0]   seq_ff, seq_in;
   logic [TS_W-1:0]    ts_ff, ts_in;
   logic [SRC_W-1:0]   src_ff, src_in;
   logic [HEND_W-1:0]  hend_ff, hend_in;
   logic [BYTE_W-1:0]  prev_ff;

   logic [HEND_W-1:0]  pos_ext;
   logic [TOT_W-1:0]   total;
   logic [HEND_W-1:0]  diff;
   logic [TOT_W-1:0]   remaining;
   logic [TOT_W-1:0]   pad;
   logic               bad_hdr;

   assign pos_ext = HEND_W'(pos_ff);

   // Field capture by byte position
   always_comb begin
      flags_in  = flags_ff;
      second_in = second_ff;
      seq_in    = seq_ff;
      ts_in     = ts_ff;
      src_in    = src_ff;
      if (pos_ff == POS_W'(0)) begin
         flags_in = rx_byte;
      end else if (pos_ff == POS_W'(1)) begin
         second_in = rx_byte;
      end else if (pos_ff < POS_W'(4)) begin
         seq_in = {seq_ff[SEQ_W-BYTE_W-1:0], rx_byte};
      end else if (pos_ff < POS_W'(8)) begin
         ts_in = {ts_ff[TS_W-BYTE_W-1:0], rx_byte};
      end else if (pos_ff < POS_W'(FIXED_HDR_BYTES)) begin
         src_in = {src_ff[SRC_W-BYTE_W-1:0], rx_byte};
      end
   end

   // Header phase and header end
   always_comb begin
      phase_in = phase_ff;
      hend_in  = hend_ff;
      case (phase_ff)
         PH_FIXED: begin
            if (pos_ff == POS_W'(FIXED_HDR_BYTES - 1)) begin
               hend_in  = HEND_W'(FIXED_HDR_BYTES) + HEND_W'({flags_ff[3:0], 2'b00});
               phase_in = flags_ff[4] ? PH_EXT_LEN : PH_DONE;
            end
         end
         PH_EXT_LEN: begin
            if (pos_ext == hend_ff + HEND_W'(3)) begin
               hend_in  = hend_ff + HEND_W'(4) + HEND_W'({prev_ff, rx_byte, 2'b00});
               phase_in = PH_DONE;
            end
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase
   end

   // Saturate the byte counter one above the largest packet
   assign pos_in = (pos_ff <= POS_W'(MAX_PACKET_BYTES)) ? pos_ff + POS_W'(1) : pos_ff;

   // Final-byte checks
   assign total     = TOT_W'(pos_ff) + TOT_W'(1);
   assign bad_hdr   = (total > TOT_W'(MAX_PACKET_BYTES)) || (phase_in != PH_DONE) ||
                      (flags_in[7:6] != RTP_VERSION) || (HEND_W'(total) < hend_in);
   assign diff      = HEND_W'(total) - hend_in;
   assign remaining = bad_hdr ? '0 : diff[TOT_W-1:0];
   assign pad       = flags_in[5] ? TOT_W'(rx_byte) : '0;

   always_comb begin
      pkt.bad         = bad_hdr || (pad > remaining);
      pkt.second_byte = second_in;
      pkt.seq         = seq_in;
      pkt.ts          = ts_in;
      pkt.src         = src_in;
      pkt.offset      = OFF_W'(hend_in);
      pkt.size        = OFF_W'(remaining - pad);
   end

   // Clear on the final byte, advance otherwise
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         phase_ff  <= PH_FIXED;
         flags_ff  <= '0;
         second_ff <= '0;
         seq_ff    <= '0;
         ts_ff     <= '0;
         src_ff    <= '0;
         hend_ff   <= '0;
         prev_ff   <= '0;
      end else if (step) begin
         if (last_byte) begin
            pos_ff    <= '0;
            phase_ff  <= PH_FIXED;
            flags_ff  <= '0;
            second_ff <= '0;
            seq_ff    <= '0;
            ts_ff     <= '0;
            src_ff    <= '0;
            hend_ff   <= '0;
            prev_ff   <= '0;
         end else begin
            pos_ff    <= pos_in;
            phase_ff  <= phase_in;
            flags_ff  <= flags_in;
            second_ff <= second_in;
            seq_ff    <= seq_in;
            ts_ff     <= ts_in;
            src_ff    <= src_in;
            hend_ff   <= hend_in;
            prev_ff   <= rx_byte;
         end
      end
   end

`ifndef ASSERT_OFF
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_W'(MAX_PACKET_BYTES + 1))
      else $error("byte counter beyond saturation");
   a_phase_fixed_early: assert property (@(posedge clock) disable iff (reset)
      (pos_ff < POS_W'(FIXED_HDR_BYTES)) |-> (phase_ff == PH_FIXED))
      else $error("header phase left fixed header early");
`endif

endmodule

[design/rhp_seq_check.sv]
// Sequence tracking, status classification and warnings for parsed packets.
`timescale 1ns / 1ps

module rhp_seq_check (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step_last,
   input  rhp_pkg::rhp_packet_type       pkt,
   input  logic [rhp_pkg::LIMIT_W-1:0]   jump_limit,
   input  logic [rhp_pkg::WIN_W-1:0]     reorder_window,
   output rhp_pkg::rhp_result_type       result
);
   import rhp_pkg::*;

   logic [SEQ_W-1:0] last_seq_ff;
   logic [TS_W-1:0]  last_ts_ff;
   logic [SRC_W-1:0] last_src_ff;
   logic             seen_ff;

   logic             in_order;
   logic [SEQ_W-1:0] seq_gap;
   logic [TS_W-1:0]  ts_step;
   rhp_status_type   status;

   assign in_order = !seen_ff || (pkt.seq == last_seq_ff + SEQ_W'(1));
   assign seq_gap  = pkt.seq - last_seq_ff;
   assign ts_step  = pkt.ts - last_ts_ff;

   always_comb begin
      if (in_order) begin
         status = ST_IN_ORDER;
      end else if (seq_gap[SEQ_W-1]) begin
         status = ST_OLD;
      end else if (seq_gap > SEQ_W'(reorder_window)) begin
         status = ST_PREMATURE;
      end else begin
         status = ST_PENDING;
      end
   end

   always_comb begin
      result = '0;
      if (pkt.bad) begin
         result.status = ST_MALFORMED;
      end else begin
         result.status       = status;
         result.ts_warn      = in_order && seen_ff &&
                               ((pkt.ts < last_ts_ff) || (ts_step > TS_W'(jump_limit)));
         result.ssrc_warn    = in_order && seen_ff && (pkt.src != last_src_ff);
         result.payload_type = pkt.second_byte[PT_W-1:0];
         result.marker       = pkt.second_byte[BYTE_W-1];
         result.seq          = pkt.seq;
         result.ts           = pkt.ts;
         result.src          = pkt.src;
         result.offset       = pkt.offset;
         result.size         = pkt.size;
      end
   end

   // Advance tracking on well-formed in-order packets only
   always_ff @(posedge clock) begin
      if (reset) begin
         last_seq_ff <= '0;
         last_ts_ff  <= '0;
         last_src_ff <= '0;
         seen_ff     <= 1'b0;
      end else if (step_last && !pkt.bad && in_order) begin
         last_seq_ff <= pkt.seq;
         last_ts_ff  <= pkt.ts;
         last_src_ff <= pkt.src;
         seen_ff     <= 1'b1;
      end
   end

`ifndef ASSERT_OFF
   a_first_in_order: assert property (@(posedge clock) disable iff (reset)
      (step_last && !pkt.bad && !seen_ff) |-> (result.status == ST_IN_ORDER))
      else $error("first packet not in order");
   a_seen_after_in_order: assert property (@(posedge clock) disable iff (reset)
      (step_last && !pkt.bad && in_order) |=> (seen_ff && last_seq_ff == $past(pkt.seq)))
      else $error("tracking not advanced");
`endif

endmodule

[design/rtp_header_parse_and_sequence_check_top.sv]
// Top level: input and result registers, configuration registers, parser and checker.
`timescale 1ns / 1ps

// RTP header parser with sequence check.
// Input channel (req_): one packet byte per item, req_last_byte high on the final
//   byte. Bytes are taken one per cycle while req_stall is low, back to back, across packets.
// Result channel (rsp_): one item per packet, produced from the final byte. It
//   carries the status (in order, malformed, old, premature, pending reorder),
//   timestamp and source warnings, the header fields, payload offset and size.
//   Malformed packets report status only, every other field zero.
// Path: a byte is held in the input register and parsed combinationally, and
//   a final byte loads its result into the result register, from which the
//   result is taken. Throughput is one byte per cycle while no final byte is
//   held (see Stall), set by the single parse pass between the input
//   register and the result register.
// Stall: while a result waits (rsp_stall high), bytes that are not final still
//   advance; a final byte is held in the input register and req_stall rises
//   until the waiting result is taken.
// Configuration (APB, pready tied high): register 0 at 0x0 is the timestamp
//   jump limit, register 1 at 0x4 the reorder window. Write only while idle.
// Reset: synchronous; clears the parse state, sequence tracking and the valid
//   flags of both channel registers, and loads limit 100000 and window 64.
module rtp_header_parse_and_sequence_check_top (
   input  logic                              clock,
   input  logic                              reset,
   // input channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [rhp_pkg::BYTE_W-1:0]        req_rx_byte,
   input  logic                              req_last_byte,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [2:0]                        rsp_status,
   output logic                              rsp_timestamp_warning,
   output logic                              rsp_ssrc_warning,
   output logic [rhp_pkg::PT_W-1:0]          rsp_payload_type,
   output logic                              rsp_marker_bit,
   output logic [rhp_pkg::SEQ_W-1:0]         rsp_sequence_number,
   output logic [rhp_pkg::TS_W-1:0]          rsp_media_timestamp,
   output logic [rhp_pkg::SRC_W-1:0]         rsp_source_id,
   output logic [rhp_pkg::OFF_W-1:0]         rsp_payload_offset,
   output logic [rhp_pkg::OFF_W-1:0]         rsp_payload_size,
   // configuration port
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [rhp_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [rhp_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [rhp_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);
   import rhp_pkg::*;

   // input register
   logic               in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0]  in_byte_ff;
   logic               in_last_ff;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   rhp_result_type     rsp_ff;

   // configuration
   logic [LIMIT_W-1:0] jump_limit_ff;
   logic [WIN_W-1:0]   window_ff;
   logic               csr_write;
   logic               csr_idx;

   logic               out_free;
   logic               proceed;
   logic               load_in;
   rhp_packet_type     pkt;
   rhp_result_type     result;

   // Handshake: a non-final byte always advances; a final byte needs room in
   // the result register, which frees up in the cycle its item is taken.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign proceed   = in_valid_ff && (!in_last_ff || out_free);
   assign req_stall = in_valid_ff && !proceed;
   assign load_in   = req_valid && !req_stall;

   always_comb begin
      if (load_in) begin
         in_valid_in = 1'b1;
      end else if (proceed) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_comb begin
      if (proceed && in_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: load the byte on accept, load the result on a final byte
   always_ff @(posedge clock) begin
      if (load_in) begin
         in_byte_ff <= req_rx_byte;
         in_last_ff <= req_last_byte;
      end
      if (proceed && in_last_ff) begin
         rsp_ff <= result;
      end
   end

   rhp_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .step      (proceed),
      .rx_byte   (in_byte_ff),
      .last_byte (in_last_ff),
      .pkt       (pkt)
   );

   rhp_seq_check u_seq_check (
      .clock          (clock),
      .reset          (reset),
      .step_last      (proceed && in_last_ff),
      .pkt            (pkt),
      .jump_limit     (jump_limit_ff),
      .reorder_window (window_ff),
      .result         (result)
   );

   // Configuration registers: word index is the address bit above the byte lanes
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_idx   = paddr[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         jump_limit_ff <= JUMP_LIMIT_RESET;
         window_ff     <= WINDOW_RESET;
      end else if (csr_write) begin
         case (csr_idx)
            CSR_IDX_JUMP_LIMIT: begin
               jump_limit_ff <= pwdata[LIMIT_W-1:0];
            end
            CSR_IDX_WINDOW: begin
               window_ff <= pwdata[WIN_W-1:0];
            end
            default: begin
               window_ff <= window_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         CSR_IDX_JUMP_LIMIT: prdata = CSR_DATA_W'(jump_limit_ff);
         CSR_IDX_WINDOW:     prdata = CSR_DATA_W'(window_ff);
         default:            prdata = '0;
      endcase
   end

   // Drive the result ports from the result register
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_ff.status;
   assign rsp_timestamp_warning = rsp_ff.ts_warn;
   assign rsp_ssrc_warning      = rsp_ff.ssrc_warn;
   assign rsp_payload_type      = rsp_ff.payload_type;
   assign rsp_marker_bit        = rsp_ff.marker;
   assign rsp_sequence_number   = rsp_ff.seq;
   assign rsp_media_timestamp   = rsp_ff.ts;
   assign rsp_source_id         = rsp_ff.src;
   assign rsp_payload_offset    = rsp_ff.offset;
   assign rsp_payload_size      = rsp_ff.size;

`ifndef ASSERT_OFF
   a_stall_only_final: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_last_ff && rsp_valid_ff && rsp_stall))
      else $error("input stalled without a blocked final byte");
   a_malformed_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_MALFORMED) |->
         (!rsp_timestamp_warning && !rsp_ssrc_warning &&
          rsp_payload_offset == '0 && rsp_payload_size == '0))
      else $error("malformed result carries fields");
   a_warn_in_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_IN_ORDER) |->
         (!rsp_timestamp_warning && !rsp_ssrc_warning))
      else $error("warning on a packet not in order");
   a_payload_fits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         ((TOT_W'(rsp_payload_offset) + TOT_W'(rsp_payload_size)) <=
          TOT_W'(MAX_PACKET_BYTES)))
      else $error("payload beyond packet length");
`endif

endmodule

[tb/tb_rtp_header_parse_and_sequence_check_top.sv]
// Self-checking testbench for the RTP header parser and sequence checker.
`timescale 1ns / 1ps

// Packets go in one byte per item, with random gaps on the sender side and
// random stall on the result side. A local model of the parser tracks the
// header capture, the payload bounds and the sequence state. For every
// accepted final byte it queues the expected result. Each result taken from
// the block is compared field by field with the oldest queued expectation.
// The run has four parts:
//   - directed packets: field extremes, header layouts, every status and
//     both warnings
//   - register extremes: zero and full-scale jump limit and window
//   - random traffic in three idling modes, each with its own register
//     setting
//   - drain, summary and verdict
module tb_rtp_header_parse_and_sequence_check_top;
   import rhp_pkg::*;

   localparam int unsigned RUN_LIMIT      = 400000;
   // Settle after the owed results are back; leave some margin
   localparam int unsigned LATENCY_SETTLE = 4;
   localparam int unsigned END_SETTLE     = 8;
   localparam int unsigned PRINT_CAP      = 100;

   // One packet as the stimulus side describes it. The bytes are built from it
   // at send time. cut_len, when non-zero, ends the packet early.
   typedef struct packed {
      logic [1:0]  version;
      logic        pad_flag;
      logic        ext_flag;
      logic [3:0]  csrc_count;
      logic        marker;
      logic [6:0]  pt;
      logic [15:0] seq;
      logic [31:0] ts;
      logic [31:0] ssrc;
      logic [15:0] ext_words;
      logic [11:0] payload_len;
      logic [7:0]  pad_fill;
      logic [7:0]  pad_count;
      logic [11:0] cut_len;
   } rtp_packet_desc;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [BYTE_W-1:0]     req_rx_byte = '0;
   logic                  req_last_byte = 1'b0;

   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [2:0]            rsp_status;
   logic                  rsp_timestamp_warning;
   logic                  rsp_ssrc_warning;
   logic [PT_W-1:0]       rsp_payload_type;
   logic                  rsp_marker_bit;
   logic [SEQ_W-1:0]      rsp_sequence_number;
   logic [TS_W-1:0]       rsp_media_timestamp;
   logic [SRC_W-1:0]      rsp_source_id;
   logic [OFF_W-1:0]      rsp_payload_offset;
   logic [OFF_W-1:0]      rsp_payload_size;

   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   rtp_header_parse_and_sequence_check_top dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_rx_byte           (req_rx_byte),
      .req_last_byte         (req_last_byte),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_status            (rsp_status),
      .rsp_timestamp_warning (rsp_timestamp_warning),
      .rsp_ssrc_warning      (rsp_ssrc_warning),
      .rsp_payload_type      (rsp_payload_type),
      .rsp_marker_bit        (rsp_marker_bit),
      .rsp_sequence_number   (rsp_sequence_number),
      .rsp_media_timestamp   (rsp_media_timestamp),
      .rsp_source_id         (rsp_source_id),
      .rsp_payload_offset    (rsp_payload_offset),
      .rsp_payload_size      (rsp_payload_size),
      .psel                  (psel),
      .penable               (penable),
      .pwrite                (pwrite),
      .paddr                 (paddr),
      .pwdata                (pwdata),
      .prdata                (prdata),
      .pready                (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Parser model: the register settings, the capture state of the packet in
   // flight and the tracking state of the last in-order packet.
   logic [LIMIT_W-1:0] jump_limit;
   logic [WIN_W-1:0]   window;

   int unsigned        pkt_pos;
   rhp_phase_type      pkt_phase;
   logic [7:0]         pkt_flags;
   logic [7:0]         pkt_second;
   logic [15:0]        pkt_seq;
   logic [31:0]        pkt_ts;
   logic [31:0]        pkt_ssrc;
   int unsigned        pkt_hdr_end;
   logic [7:0]         pkt_prev;

   logic [15:0]        trk_seq;
   logic [31:0]        trk_ts;
   logic [31:0]        trk_ssrc;
   logic               trk_valid;

   // Results still owed by the block, oldest first
   rhp_result_type     expected_results[$];
   rhp_result_type     head_result;

   int unsigned        send_idle_pct = 0;
   int unsigned        rsp_stall_pct = 0;
   int unsigned        bytes_sent = 0;
   int unsigned        packets_sent = 0;
   int unsigned        mismatch_count = 0;
   int unsigned        cycle_count = 0;
   int unsigned        status_count[5] = '{default: 0};
   int unsigned        ts_warn_count = 0;
   int unsigned        ssrc_warn_count = 0;

   task automatic clear_packet_capture();
      pkt_pos     = 0;
      pkt_phase   = PH_FIXED;
      pkt_flags   = '0;
      pkt_second  = '0;
      pkt_seq     = '0;
      pkt_ts      = '0;
      pkt_ssrc    = '0;
      pkt_hdr_end = 0;
      pkt_prev    = '0;
   endtask

   // Advance the model by one accepted byte; on a final byte queue the result.
   task automatic predict_octet(input logic [7:0] value, input logic is_final);
      int unsigned    pos;
      int unsigned    total;
      int unsigned    remaining;
      int unsigned    pad_len;
      logic           bad;
      logic [15:0]    seq_gap;
      rhp_result_type res;

      pos = pkt_pos;
      if (pos == 0) begin
         pkt_flags = value;
      end else if (pos == 1) begin
         pkt_second = value;
      end else if (pos < 4) begin
         pkt_seq = {pkt_seq[7:0], value};
      end else if (pos < 8) begin
         pkt_ts = {pkt_ts[23:0], value};
      end else if (pos < 12) begin
         pkt_ssrc = {pkt_ssrc[23:0], value};
      end

      // Header end grows by the CSRC list, then by the extension word count
      if (pkt_phase == PH_FIXED && pos == 11) begin
         pkt_hdr_end = 12 + 4 * int'(pkt_flags[3:0]);
         pkt_phase   = pkt_flags[4] ? PH_EXT_LEN : PH_DONE;
      end else if (pkt_phase == PH_EXT_LEN && pos == pkt_hdr_end + 3) begin
         pkt_hdr_end = pkt_hdr_end + 4 + 4 * int'({pkt_prev, value});
         pkt_phase   = PH_DONE;
      end
      pkt_prev = value;
      if (pkt_pos <= MAX_PACKET_BYTES) pkt_pos = pkt_pos + 1;

      if (!is_final) return;

      total = pos + 1;
      bad = (total > MAX_PACKET_BYTES) || (pkt_phase != PH_DONE) ||
            (pkt_flags[7:6] != RTP_VERSION) || (total < pkt_hdr_end);
      remaining = bad ? 0 : total - pkt_hdr_end;
      pad_len = pkt_flags[5] ? int'(value) : 0;
      if (pad_len > remaining) bad = 1'b1;

      res = '0;
      if (bad) begin
         res.status = ST_MALFORMED;
      end else begin
         if (!trk_valid) begin
            trk_seq  = pkt_seq - 16'd1;
            trk_ts   = pkt_ts;
            trk_ssrc = pkt_ssrc;
         end
         if (pkt_seq == trk_seq + 16'd1) begin
            res.status = ST_IN_ORDER;
            if (trk_valid) begin
               res.ts_warn   = (pkt_ts < trk_ts) || (pkt_ts - trk_ts > {1'b0, jump_limit});
               res.ssrc_warn = (pkt_ssrc != trk_ssrc);
            end
            trk_seq   = pkt_seq;
            trk_ts    = pkt_ts;
            trk_ssrc  = pkt_ssrc;
            trk_valid = 1'b1;
         end else begin
            seq_gap = pkt_seq - trk_seq;
            if (seq_gap[15])
               res.status = ST_OLD;
            else if (seq_gap > {1'b0, window})
               res.status = ST_PREMATURE;
            else
               res.status = ST_PENDING;
         end
         res.payload_type = pkt_second[6:0];
         res.marker       = pkt_second[7];
         res.seq          = pkt_seq;
         res.ts           = pkt_ts;
         res.src          = pkt_ssrc;
         res.offset       = pkt_hdr_end[OFF_W-1:0];
         res.size         = OFF_W'(remaining - pad_len);
      end

      status_count[int'(res.status)]++;
      ts_warn_count   += res.ts_warn;
      ssrc_warn_count += res.ssrc_warn;
      expected_results.push_back(res);
      clear_packet_capture();
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatch_count < PRINT_CAP)
         $display("MISMATCH %s at %0t: got 0x%0h, expected 0x%0h", what, $realtime, got, want);
      mismatch_count++;
   endtask

   task automatic check_field(input string what, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) report_mismatch(what, got, want);
   endtask

   // Result side: pick a fresh stall every cycle, check every item taken.
   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // Sample mid-cycle: the item moves at the next rising edge
   always @(negedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_results.size() == 0) begin
            report_mismatch("result with no packet pending", 32'(rsp_status), 32'd0);
         end else begin
            head_result = expected_results.pop_front();
            check_field("status", 32'(rsp_status), 32'(head_result.status));
            check_field("timestamp_warning", 32'(rsp_timestamp_warning),
                        32'(head_result.ts_warn));
            check_field("ssrc_warning", 32'(rsp_ssrc_warning), 32'(head_result.ssrc_warn));
            check_field("payload_type", 32'(rsp_payload_type),
                        32'(head_result.payload_type));
            check_field("marker_bit", 32'(rsp_marker_bit), 32'(head_result.marker));
            check_field("sequence_number", 32'(rsp_sequence_number), 32'(head_result.seq));
            check_field("media_timestamp", rsp_media_timestamp, head_result.ts);
            check_field("source_id", rsp_source_id, head_result.src);
            check_field("payload_offset", 32'(rsp_payload_offset), 32'(head_result.offset));
            check_field("payload_size", 32'(rsp_payload_size), 32'(head_result.size));
         end
      end
   end

   // Sender: idle at random, then hold the item until it is taken. Valid stays
   // high on exit so that the next byte can follow in the very next cycle.
   task automatic send_octet(input logic [7:0] value, input logic is_final);
      logic taken;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_rx_byte   <= value;
      req_last_byte <= is_final;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end
      predict_octet(value, is_final);
      bytes_sent++;
   endtask

   // Build the bytes of a packet and send them, marking the final one.
   task automatic send_packet(input rtp_packet_desc d);
      logic [7:0] octets[$];
      int         n;
      octets = {};
      octets.push_back({d.version, d.pad_flag, d.ext_flag, d.csrc_count});
      octets.push_back({d.marker, d.pt});
      octets.push_back(d.seq[15:8]);
      octets.push_back(d.seq[7:0]);
      for (int i = 3; i >= 0; i--) octets.push_back(d.ts[8*i +: 8]);
      for (int i = 3; i >= 0; i--) octets.push_back(d.ssrc[8*i +: 8]);
      repeat (4 * int'(d.csrc_count)) octets.push_back(8'($urandom));
      if (d.ext_flag) begin
         octets.push_back(8'($urandom));
         octets.push_back(8'($urandom));
         octets.push_back(d.ext_words[15:8]);
         octets.push_back(d.ext_words[7:0]);
         // A huge word count only ever comes with a cut
         if (d.cut_len == 0) repeat (4 * int'(d.ext_words)) octets.push_back(8'($urandom));
      end
      repeat (int'(d.payload_len)) octets.push_back(8'($urandom));
      if (d.pad_flag) begin
         repeat (int'(d.pad_fill)) octets.push_back(8'($urandom));
         octets.push_back(d.pad_count);
      end
      n = (d.cut_len != 0 && int'(d.cut_len) < octets.size()) ? int'(d.cut_len) : octets.size();
      for (int i = 0; i < n; i++) send_octet(octets[i], i == n - 1);
      packets_sent++;
   endtask

   function automatic rtp_packet_desc plain_packet(input logic [15:0] seq,
                                                   input logic [31:0] ts,
                                                   input logic [31:0] ssrc);
      rtp_packet_desc d;
      d         = '0;
      d.version = RTP_VERSION;
      d.seq     = seq;
      d.ts      = ts;
      d.ssrc    = ssrc;
      return d;
   endfunction

   // Drop valid, wait until every owed result is back, then settle.
   task automatic wait_results_drained(input int unsigned settle);
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic check_register(input logic idx, input logic [31:0] want);
      logic [31:0] got;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      @(negedge clock);
      got = prdata;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      check_field(idx == CSR_IDX_JUMP_LIMIT ? "jump limit readback" : "window readback",
                  got, want);
   endtask

   // Write a register (only while idle), mirror it in the model, read it back.
   task automatic write_register(input logic idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (idx == CSR_IDX_JUMP_LIMIT) jump_limit = value[LIMIT_W-1:0];
      else                           window     = value[WIN_W-1:0];
      check_register(idx, idx == CSR_IDX_JUMP_LIMIT ? 32'(jump_limit) : 32'(window));
   endtask

   task automatic test_register_reset_values();
      check_register(CSR_IDX_JUMP_LIMIT, 32'(JUMP_LIMIT_RESET));
      check_register(CSR_IDX_WINDOW, 32'(WINDOW_RESET));
   endtask

   task automatic test_in_order_and_warnings();
      rtp_packet_desc d;
      // First packet seeds tracking; sequence at the top so the next one wraps
      send_packet(plain_packet(16'hFFFF, 32'd0, 32'd0));
      // Step of exactly the limit: no timestamp warning, but a new source
      d = plain_packet(trk_seq + 16'd1, trk_ts + 32'd100000, 32'hFFFF_FFFF);
      d.marker      = 1'b1;
      d.pt          = 7'h7F;
      d.payload_len = 12'd4;
      send_packet(d);
      // One past the limit, then backwards
      send_packet(plain_packet(trk_seq + 16'd1, trk_ts + 32'd100001, trk_ssrc));
      send_packet(plain_packet(trk_seq + 16'd1, trk_ts - 32'd1, trk_ssrc));
   endtask

   task automatic test_header_layouts();
      rtp_packet_desc d;
      d = plain_packet(trk_seq + 16'd1, trk_ts + 32'd10, trk_ssrc);
      d.csrc_count  = 4'hF;
      d.payload_len = 12'd3;
      send_packet(d);
      d = plain_packet(trk_seq + 16'd1, trk_ts + 32'd10, trk_ssrc);
      d.ext_flag    = 1'b1;
      d.ext_words   = 16'd3;
      d.payload_len = 12'd5;
      send_packet(d);
      // CSRCs, empty extension and proper padding together
      d = plain_packet(trk_seq + 16'd1, trk_ts + 32'd10, trk_ssrc);
      d.csrc_count  = 4'd2;
      d.ext_flag    = 1'b1;
      d.payload_len = 12'd6;
      d.pad_flag    = 1'b1;
      d.pad_fill    = 8'd3;
      d.pad_count   = 8'd4;
      send_packet(d);
      // Padding flag set but a zero count: strip nothing
      d = plain_packet(trk_seq + 16'd1, trk_ts + 32'd10, trk_ssrc);
      d.payload_len = 12'd2;
      d.pad_flag    = 1'b1;
      send_packet(d);
      // Hold the sender until every result is back
      wait_results_drained(0);
   endtask

   task automatic test_malformed_packets();
      rtp_packet_desc d;
      d = plain_packet(trk_seq + 16'd1, trk_ts, trk_ssrc);
      d.payload_len = 12'd2;
      d.pad_flag    = 1'b1;
      d.pad_count   = 8'd200;
      send_packet(d);
      for (int v = 0; v < 4; v++) begin
         if (v == int'(RTP_VERSION)) continue;
         d = plain_packet(trk_seq + 16'd1, trk_ts, trk_ssrc);
         d.version     = 2'(v);
         d.payload_len = 12'd3;
         send_packet(d);
      end
      // Ends inside the fixed header, on its first byte, inside the CSRCs
      d = plain_packet(trk_seq + 16'd1, trk_ts, trk_ssrc);
      d.cut_len = 12'd5;
      send_packet(d);
      d.cut_len = 12'd1;
      send_packet(d);
      d.csrc_count = 4'd4;
      d.cut_len    = 12'd20;
      send_packet(d);
      // Ends before the extension length, then a length far past the end
      d = plain_packet(trk_seq + 16'd1, trk_ts, trk_ssrc);
      d.ext_flag = 1'b1;
      d.cut_len  = 12'd14;
      send_packet(d);
      d.ext_words = 16'hFFFF;
      d.cut_len   = 12'd20;
      send_packet(d);
   endtask

   task automatic test_sequence_distance();
      send_packet(plain_packet(trk_seq + 16'd1, trk_ts + 32'd10, trk_ssrc));
      // Duplicate counts as pending
      send_packet(plain_packet(trk_seq, trk_ts, trk_ssrc));
      send_packet(plain_packet(trk_seq - 16'd100, trk_ts, trk_ssrc));
      send_packet(plain_packet(trk_seq + 16'd65, trk_ts, trk_ssrc));
      send_packet(plain_packet(trk_seq + 16'd64, trk_ts, trk_ssrc));
      send_packet(plain_packet(trk_seq + 16'h8000, trk_ts, trk_ssrc));
   endtask

   task automatic test_size_extremes();
      rtp_packet_desc d;
      // Largest legal packet, then a header ending right at the size limit
      d = plain_packet(trk_seq + 16'd1, trk_ts + 32'd10, trk_ssrc);
      d.payload_len = 12'd2036;
      send_packet(d);
      d = plain_packet(trk_seq + 16'd1, trk_ts + 32'd10, trk_ssrc);
      d.csrc_count = 4'hF;
      d.ext_flag   = 1'b1;
      d.ext_words  = 16'd493;
      send_packet(d);
      // One byte too many, then well past: the byte counter saturates
      d = plain_packet(trk_seq + 16'd1, trk_ts + 32'd10, trk_ssrc);
      d.payload_len = 12'd2037;
      send_packet(d);
      d.payload_len = 12'd2100;
      send_packet(d);
      send_packet(plain_packet(trk_seq + 16'd1, trk_ts + 32'd10, trk_ssrc));
   endtask

   task automatic test_register_extremes();
      wait_results_drained(LATENCY_SETTLE);
      write_register(CSR_IDX_JUMP_LIMIT, 32'd0);
      write_register(CSR_IDX_WINDOW, 32'd0);
      send_packet(plain_packet(trk_seq + 16'd1, trk_ts, trk_ssrc));
      send_packet(plain_packet(trk_seq + 16'd1, trk_ts + 32'd1, trk_ssrc));
      send_packet(plain_packet(trk_seq + 16'd2, trk_ts, trk_ssrc));
      send_packet(plain_packet(trk_seq, trk_ts, trk_ssrc));
      wait_results_drained(LATENCY_SETTLE);
      // All ones: the unused top bits must be dropped
      write_register(CSR_IDX_JUMP_LIMIT, 32'hFFFF_FFFF);
      write_register(CSR_IDX_WINDOW, 32'hFFFF_FFFF);
      send_packet(plain_packet(trk_seq + 16'd1, trk_ts + 32'h7FFF_FFFF, trk_ssrc));
      send_packet(plain_packet(trk_seq + 16'd1, trk_ts + 32'h8000_0000, trk_ssrc));
      send_packet(plain_packet(trk_seq + 16'h7FFF, trk_ts, trk_ssrc));
      send_packet(plain_packet(trk_seq + 16'h8000, trk_ts, trk_ssrc));
   endtask

   // Mostly well-formed packets with random content and sequence offsets;
   // about one in eight is broken on purpose.
   task automatic test_random_traffic(input int unsigned sender_idle,
                                      input int unsigned sink_idle,
                                      input logic [31:0] limit_val,
                                      input logic [31:0] window_val);
      rtp_packet_desc d;
      int unsigned    start_bytes;
      int unsigned    start_packets;
      int unsigned    pick;
      wait_results_drained(LATENCY_SETTLE);
      write_register(CSR_IDX_JUMP_LIMIT, limit_val);
      write_register(CSR_IDX_WINDOW, window_val);
      send_idle_pct = sender_idle;
      rsp_stall_pct = sink_idle;
      start_bytes   = bytes_sent;
      start_packets = packets_sent;
      while (bytes_sent - start_bytes < 135 || packets_sent - start_packets < 20) begin
         d = plain_packet(trk_seq + 16'd1, trk_ts + $urandom_range(0, 200000), trk_ssrc);
         d.marker = 1'($urandom_range(1));
         d.pt     = 7'($urandom);
         pick = $urandom_range(99);
         if (pick < 8)
            d.seq = 16'($urandom);
         else if (pick < 16)
            d.seq = trk_seq - 16'($urandom_range(0, 300));
         else if (pick < 28)
            d.seq = trk_seq + 16'($urandom_range(2, 100));
         if ($urandom_range(9) == 0) d.ts = $urandom;
         if ($urandom_range(9) == 0) d.ssrc = $urandom;
         d.csrc_count = ($urandom_range(4) == 0) ? 4'($urandom) : 4'($urandom_range(2));
         if ($urandom_range(3) == 0) begin
            d.ext_flag  = 1'b1;
            d.ext_words = 16'($urandom_range(4));
         end
         d.payload_len = ($urandom_range(30) == 0) ? 12'($urandom_range(100, 400))
                                                   : 12'($urandom_range(16));
         if ($urandom_range(3) == 0) begin
            d.pad_flag  = 1'b1;
            d.pad_fill  = 8'($urandom_range(7));
            d.pad_count = ($urandom_range(5) == 0) ? 8'd0 : d.pad_fill + 8'd1;
         end
         if ($urandom_range(99) < 12) begin
            case ($urandom_range(3))
               0: begin
                  d.version = 2'($urandom);
               end
               1: begin
                  d.cut_len = 12'($urandom_range(1, 40));
               end
               2: begin
                  d.pad_flag  = 1'b1;
                  d.pad_count = 8'($urandom);
               end
               default: begin
                  d.ext_flag  = 1'b1;
                  d.ext_words = 16'($urandom);
                  d.cut_len   = 12'($urandom_range(12, 64));
               end
            endcase
         end
         send_packet(d);
         if ($urandom_range(49) == 0) wait_results_drained(0);
      end
   endtask

   // Watchdog: end the run if it hangs
   initial begin
      while (cycle_count < RUN_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timed out after %0d cycles, %0d results outstanding",
               cycle_count, expected_results.size());
      $display("Verification failed");
      $finish;
   end

   initial begin
      jump_limit = JUMP_LIMIT_RESET;
      window     = WINDOW_RESET;
      clear_packet_capture();
      trk_seq   = '0;
      trk_ts    = '0;
      trk_ssrc  = '0;
      trk_valid = 1'b0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 33;
      rsp_stall_pct = 78;
      test_register_reset_values();
      test_in_order_and_warnings();
      test_header_layouts();
      test_malformed_packets();
      test_sequence_distance();
      test_size_extremes();
      test_register_extremes();

      test_random_traffic(33, 78, 32'd100000, 32'd64);
      test_random_traffic(78, 33, $urandom_range(0, 300000), $urandom_range(0, 300));
      test_random_traffic(0, 0, $urandom, $urandom);

      wait_results_drained(END_SETTLE);
      $display("Covered %0d bytes in %0d packets: %0d in order, %0d malformed,",
               bytes_sent, packets_sent, status_count[ST_IN_ORDER],
               status_count[ST_MALFORMED]);
      $display("  %0d old, %0d premature, %0d pending", status_count[ST_OLD],
               status_count[ST_PREMATURE], status_count[ST_PENDING]);
      $display("Timestamp warnings %0d, source warnings %0d, mismatches %0d",
               ts_warn_count, ssrc_warn_count, mismatch_count);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

[filelist.f]
design/rhp_pkg.sv
design/rhp_parse.sv
design/rhp_seq_check.sv
design/rtp_header_parse_and_sequence_check_top.sv
tb/tb_rtp_header_parse_and_sequence_check_top.sv
